// ===== src/tsm_pkg.sv =====
package tsm_pkg;

    localparam int NUM_SEGS   = 8;
    localparam int NUM_RANGES = 8;

    localparam int SEG_W      = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
    localparam int SEG_CNT_W  = $clog2(NUM_SEGS + 1);
    localparam int RNG_W      = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int RNG_CNT_W  = $clog2(NUM_RANGES + 1);
    localparam int RA_DEPTH   = NUM_SEGS * NUM_RANGES;
    localparam int RA_W       = (RA_DEPTH > 1) ? $clog2(RA_DEPTH) : 1;

    localparam int TIME_W     = 24;
    localparam int MASK_W     = 32;

    localparam logic [1:0] CMD_EVAL  = 2'd0;
    localparam logic [1:0] CMD_HDR   = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;

    localparam logic [3:0] KIND_DAILY       = 4'd0;
    localparam logic [3:0] KIND_WEEKLY      = 4'd1;
    localparam logic [3:0] KIND_MONTHLY     = 4'd2;
    localparam logic [3:0] KIND_FIRST_MONTH = 4'd3;

    typedef struct packed {
        logic              include_flag;
        logic [3:0]        seg_kind;
        logic [MASK_W-1:0] day_mask;
        logic [3:0]        range_total;
    } hdr_t;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
    } rng_t;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [2:0]        weekday;
        logic [4:0]        month_day;
        logic [3:0]        month;
    } qry_t;

    typedef struct packed {
        logic day_ok;
        logic range_hit;
    } match_t;

endpackage

// ===== src/tsm_if.sv =====
interface tsm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  seg_index;
    logic [2:0]  range_index;
    logic        include_flag;
    logic [3:0]  seg_kind;
    logic [31:0] day_mask;
    logic [3:0]  range_total;
    logic [23:0] time_a;
    logic [23:0] time_b;
    logic [2:0]  weekday;
    logic [4:0]  month_day;
    logic [3:0]  month;

    modport source (
        output valid, cmd, seg_index, range_index, include_flag, seg_kind, day_mask,
               range_total, time_a, time_b, weekday, month_day, month,
        input  ready
    );
    modport sink (
        input  valid, cmd, seg_index, range_index, include_flag, seg_kind, day_mask,
               range_total, time_a, time_b, weekday, month_day, month,
        output ready
    );
endinterface

interface tsm_result_if;
    logic valid;
    logic ready;
    logic allowed;
    logic excluded;

    modport source (output valid, allowed, excluded, input ready);
    modport sink   (input valid, allowed, excluded, output ready);
endinterface

interface tsm_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/time_schedule_matcher.sv =====
// Schedule matcher: holds a table of up to NUM_SEGS include/exclude segments, each
// with a day rule and up to NUM_RANGES time-of-day ranges, and answers whether a
// calendar time is allowed. An evaluate walks the segments in use, reading segment
// headers one at a time and comparing one range per cycle through the single read
// ports of the header and range memories, and a segment stops at its first matching
// range. The block is not ready while an item is in flight; the result register
// lets the next item enter while a result waits. Table entries have no reset and
// must be written before use.
module time_schedule_matcher (
    input  logic       clk,
    input  logic       rst_n,
    tsm_cfg_if.sink    cfg,
    tsm_item_if.sink   item,
    tsm_result_if.source result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_CHK,
        ST_RNG_CHK,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [3:0]                    seg_use_reg;
    logic [tsm_pkg::SEG_CNT_W-1:0] used_reg, used_next;
    logic [tsm_pkg::SEG_CNT_W-1:0] seg_cnt_reg, seg_cnt_next;
    logic [tsm_pkg::SEG_CNT_W-1:0] seg_cnt_inc;
    logic [tsm_pkg::RNG_CNT_W-1:0] rng_cnt_reg, rng_cnt_next;
    logic [tsm_pkg::RNG_CNT_W-1:0] rng_cnt_inc;
    logic [tsm_pkg::RNG_CNT_W-1:0] n_reg, n_next;
    logic [tsm_pkg::RNG_CNT_W-1:0] n_hdr;
    logic                          inc_reg, inc_next;
    logic                          any_inc_reg, any_inc_next;
    logic                          exc_reg, exc_next;
    logic                          res_valid_reg, res_valid_next;
    logic                          res_allowed_reg, res_allowed_next;
    logic                          res_excluded_reg, res_excluded_next;
    tsm_pkg::qry_t                 qry_reg;

    logic                          accept;
    logic                          hdr_we, rng_we, hdr_re, rng_re;
    logic [tsm_pkg::SEG_W-1:0]     hdr_wr_addr, seg_idx;
    logic [tsm_pkg::RA_W-1:0]      rng_wr_addr, rng_rd_addr;
    logic [tsm_pkg::RNG_CNT_W-1:0] rng_sel;
    logic [$bits(tsm_pkg::hdr_t)-1:0] hdr_rd_data;
    logic [$bits(tsm_pkg::rng_t)-1:0] rng_rd_data;
    tsm_pkg::hdr_t                 hdr_wr, hdr_q;
    tsm_pkg::rng_t                 rng_wr, rng_q;
    tsm_pkg::match_t               match;

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    assign result.valid    = res_valid_reg;
    assign result.allowed  = res_allowed_reg;
    assign result.excluded = res_excluded_reg;

    // table writes go straight to the memories in the accept cycle
    assign hdr_wr.include_flag = item.include_flag;
    assign hdr_wr.seg_kind     = item.seg_kind;
    assign hdr_wr.day_mask     = item.day_mask;
    assign hdr_wr.range_total  = item.range_total;
    assign rng_wr.start        = item.time_a;
    assign rng_wr.stop         = item.time_b;

    assign hdr_we = accept && (item.cmd == tsm_pkg::CMD_HDR) &&
                    (32'(item.seg_index) < tsm_pkg::NUM_SEGS);
    assign rng_we = accept && (item.cmd == tsm_pkg::CMD_RANGE) &&
                    (32'(item.seg_index) < tsm_pkg::NUM_SEGS) &&
                    (32'(item.range_index) < tsm_pkg::NUM_RANGES);
    assign hdr_wr_addr = tsm_pkg::SEG_W'(item.seg_index);
    assign rng_wr_addr = tsm_pkg::RA_W'(32'(item.seg_index) * tsm_pkg::NUM_RANGES +
                                        32'(item.range_index));

    assign seg_cnt_inc = seg_cnt_reg + 1'b1;
    assign rng_cnt_inc = rng_cnt_reg + 1'b1;
    assign seg_idx     = seg_cnt_reg[tsm_pkg::SEG_W-1:0];

    // prefetch the next range while the current one is compared
    assign hdr_re  = (state_reg == ST_HDR_RD);
    assign rng_sel = (state_reg == ST_RNG_CHK) ? rng_cnt_inc : '0;
    assign rng_re  = ((state_reg == ST_HDR_CHK) && match.day_ok && (n_hdr != '0)) ||
                     ((state_reg == ST_RNG_CHK) && !match.range_hit && (rng_cnt_inc != n_reg));
    assign rng_rd_addr = tsm_pkg::RA_W'(32'(seg_idx) * tsm_pkg::NUM_RANGES + 32'(rng_sel));

    assign hdr_q = tsm_pkg::hdr_t'(hdr_rd_data);
    assign rng_q = tsm_pkg::rng_t'(rng_rd_data);

    assign n_hdr = (32'(hdr_q.range_total) > tsm_pkg::NUM_RANGES) ?
                   tsm_pkg::RNG_CNT_W'(tsm_pkg::NUM_RANGES) :
                   tsm_pkg::RNG_CNT_W'(hdr_q.range_total);

    tsm_ram #(
        .WIDTH ($bits(tsm_pkg::hdr_t)),
        .DEPTH (tsm_pkg::NUM_SEGS)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (hdr_we),
        .wr_addr (hdr_wr_addr),
        .wr_data (hdr_wr),
        .rd_en   (hdr_re),
        .rd_addr (seg_idx),
        .rd_data (hdr_rd_data)
    );

    tsm_ram #(
        .WIDTH ($bits(tsm_pkg::rng_t)),
        .DEPTH (tsm_pkg::RA_DEPTH)
    ) u_rng_ram (
        .clk     (clk),
        .wr_en   (rng_we),
        .wr_addr (rng_wr_addr),
        .wr_data (rng_wr),
        .rd_en   (rng_re),
        .rd_addr (rng_rd_addr),
        .rd_data (rng_rd_data)
    );

    tsm_match_unit u_match (
        .hdr (hdr_q),
        .rng (rng_q),
        .qry (qry_reg),
        .res (match)
    );

    always_comb
    begin
        logic seg_done;
        logic seg_hit;
        logic seg_inc;

        seg_done          = 1'b0;
        seg_hit           = 1'b0;
        seg_inc           = inc_reg;
        state_next        = state_reg;
        used_next         = used_reg;
        seg_cnt_next      = seg_cnt_reg;
        rng_cnt_next      = rng_cnt_reg;
        n_next            = n_reg;
        inc_next          = inc_reg;
        any_inc_next      = any_inc_reg;
        exc_next          = exc_reg;
        res_valid_next    = res_valid_reg;
        res_allowed_next  = res_allowed_reg;
        res_excluded_next = res_excluded_reg;

        if (result.valid && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    any_inc_next = 1'b0;
                    exc_next     = 1'b0;
                    seg_cnt_next = '0;
                    used_next    = (32'(seg_use_reg) > tsm_pkg::NUM_SEGS) ?
                                   tsm_pkg::SEG_CNT_W'(tsm_pkg::NUM_SEGS) :
                                   tsm_pkg::SEG_CNT_W'(seg_use_reg);
                    if ((item.cmd == tsm_pkg::CMD_EVAL) && (used_next != '0))
                    begin
                        state_next = ST_HDR_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HDR_RD:
            begin
                state_next = ST_HDR_CHK;
            end
            ST_HDR_CHK:
            begin
                seg_inc = hdr_q.include_flag;
                if (!match.day_ok)
                begin
                    seg_done = 1'b1;
                end
                else if (n_hdr == '0)
                begin
                    seg_done = 1'b1;
                    seg_hit  = 1'b1;
                end
                else
                begin
                    inc_next     = hdr_q.include_flag;
                    n_next       = n_hdr;
                    rng_cnt_next = '0;
                    state_next   = ST_RNG_CHK;
                end
            end
            ST_RNG_CHK:
            begin
                if (match.range_hit)
                begin
                    seg_done = 1'b1;
                    seg_hit  = 1'b1;
                end
                else if (rng_cnt_inc == n_reg)
                begin
                    seg_done = 1'b1;
                end
                else
                begin
                    rng_cnt_next = rng_cnt_inc;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next    = 1'b1;
                    res_allowed_next  = any_inc_reg && !exc_reg;
                    res_excluded_next = exc_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (seg_done)
        begin
            if (seg_hit && seg_inc)
            begin
                any_inc_next = 1'b1;
            end
            if (seg_hit && !seg_inc)
            begin
                exc_next = 1'b1;
            end
            if (seg_cnt_inc == used_reg)
            begin
                state_next = ST_DONE;
            end
            else
            begin
                seg_cnt_next = seg_cnt_inc;
                state_next   = ST_HDR_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seg_use_reg      <= 4'd0;
            used_reg         <= '0;
            seg_cnt_reg      <= '0;
            rng_cnt_reg      <= '0;
            n_reg            <= '0;
            inc_reg          <= 1'b0;
            any_inc_reg      <= 1'b0;
            exc_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_allowed_reg  <= 1'b0;
            res_excluded_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                seg_use_reg <= cfg.data;
            end
            state_reg        <= state_next;
            used_reg         <= used_next;
            seg_cnt_reg      <= seg_cnt_next;
            rng_cnt_reg      <= rng_cnt_next;
            n_reg            <= n_next;
            inc_reg          <= inc_next;
            any_inc_reg      <= any_inc_next;
            exc_reg          <= exc_next;
            res_valid_reg    <= res_valid_next;
            res_allowed_reg  <= res_allowed_next;
            res_excluded_reg <= res_excluded_next;
        end
    end

    // hold the query for the whole walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qry_reg.now       <= item.time_a;
            qry_reg.weekday   <= item.weekday;
            qry_reg.month_day <= item.month_day;
            qry_reg.month     <= item.month;
        end
    end

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.cmd != tsm_pkg::CMD_EVAL)) |=> (state_reg == ST_DONE))
        else $error("table write did not finish in one cycle");

    a_rng_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RNG_CHK) |-> ((rng_cnt_reg < n_reg) && (n_reg != '0)))
        else $error("range counter beyond segment range count");

    a_seg_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HDR_RD) || (state_reg == ST_HDR_CHK) ||
         (state_reg == ST_RNG_CHK)) |-> (seg_cnt_reg < used_reg))
        else $error("segment counter beyond segments in use");

    a_allowed_not_excluded: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.allowed && result.excluded))
        else $error("result both allowed and excluded");

endmodule

// ===== src/tsm_ram.sv =====
module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/tsm_match_unit.sv =====
module tsm_match_unit (
    input  tsm_pkg::hdr_t   hdr,
    input  tsm_pkg::rng_t   rng,
    input  tsm_pkg::qry_t   qry,
    output tsm_pkg::match_t res
);

    logic [3:0] month_of_kind;

    assign month_of_kind = hdr.seg_kind - tsm_pkg::KIND_FIRST_MONTH;

    always_comb
    begin
        case (hdr.seg_kind)
            tsm_pkg::KIND_DAILY:   res.day_ok = 1'b1;
            tsm_pkg::KIND_WEEKLY:  res.day_ok = hdr.day_mask[5'(qry.weekday)];
            // day zero selects no bit
            tsm_pkg::KIND_MONTHLY: res.day_ok = (qry.month_day != 5'd0) &&
                                                hdr.day_mask[qry.month_day - 5'd1];
            default:               res.day_ok = (month_of_kind == qry.month);
        endcase
        res.range_hit = (qry.now >= rng.start) && (qry.now < rng.stop);
    end

endmodule
